// ===== src/wifp_pkg.sv =====
`default_nettype none

package wifp_pkg;

   localparam int DEVICE_COUNT    = 4;
   localparam int MIN_FRAME_BYTES = 16;

   localparam int BYTE_W      = 8;
   localparam int DEV_W       = 3;
   localparam int POS_W       = 5;
   localparam int INT_ACC_W   = 24;
   localparam int FRAC_ACC_W  = 20;
   localparam int FRAC_CNT_W  = 3;
   localparam int SCALE_W     = 20;
   localparam int INT_PROD_W  = INT_ACC_W + SCALE_W;
   localparam int FRAC_PROD_W = FRAC_ACC_W + SCALE_W;
   localparam int WEIGHT_W    = 45;
   localparam int DEV_IDX_W   = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Byte positions inside a frame.
   localparam logic [POS_W-1:0] POS_HDR_0    = 5'd0;
   localparam logic [POS_W-1:0] POS_HDR_1    = 5'd1;
   localparam logic [POS_W-1:0] POS_COMMA_A  = 5'd2;
   localparam logic [POS_W-1:0] POS_COMMA_B  = 5'd5;
   localparam logic [POS_W-1:0] POS_SIGN     = 5'd6;
   localparam logic [POS_W-1:0] POS_NUM_LO   = 5'd7;
   localparam logic [POS_W-1:0] POS_NUM_HI   = 5'd13;

   localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;

   localparam logic [SCALE_W-1:0] INT_SCALE = 20'd1000000;

   // Summary of one frame, handed over on its last byte.
   typedef struct packed {
      logic [INT_ACC_W-1:0]  int_acc;
      logic [FRAC_ACC_W-1:0] frac_acc;
      logic [FRAC_CNT_W-1:0] frac_digits;
      logic                  sign_negative;
      logic                  ok;
      logic                  dev_ok;
      logic [DEV_W-1:0]      device;
   } frame_sum_type;

   // Weight of the fraction digits so the value lands on six places.
   function automatic logic [SCALE_W-1:0] frac_scale(input logic [FRAC_CNT_W-1:0] digits);
      logic [SCALE_W-1:0] s;
      case (digits)
         3'd0:    s = 20'd1000000;
         3'd1:    s = 20'd100000;
         3'd2:    s = 20'd10000;
         3'd3:    s = 20'd1000;
         3'd4:    s = 20'd100;
         3'd5:    s = 20'd10;
         default: s = 20'd1;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== src/wifp_if.sv =====
`default_nettype none

interface wifp_req_if;
   import wifp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_end;
   logic [DEV_W-1:0]  device;

   modport source (output valid, data_byte, frame_end, device, input ready);
   modport sink   (input valid, data_byte, frame_end, device, output ready);
endinterface

interface wifp_rsp_if;
   import wifp_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [DEV_W-1:0]           device_out;
   logic                       accepted;
   logic signed [WEIGHT_W-1:0] weight_micro;
   logic                       weight_valid;

   modport source (output valid, device_out, accepted, weight_micro, weight_valid,
                   input ready);
   modport sink   (input valid, device_out, accepted, weight_micro, weight_valid,
                   output ready);
endinterface

`default_nettype wire

// ===== src/weigh_indicator_frame_parser_top.sv =====
`default_nettype none

// Frame parser for an ASCII load-cell indicator: it takes one frame byte per
// cycle on req_chan and checks it on the fly, so a new byte can follow every
// cycle. On the byte marked frame_end one response becomes valid on rsp_chan once
// that transfer has passed the three end-of-frame registers (frame summary,
// multiply by the digit scales, add and sign). The response gives the device,
// whether the frame was accepted and the weight stored for that device in
// millionths. While a response is held by the sink, bytes keep flowing until
// all three end-of-frame stages hold a frame end; then req_chan.ready drops until
// the sink takes the response. Weight stores read as zero and not valid after reset.
module weigh_indicator_frame_parser_top (
   input wire         clock,
   input wire         reset,
   wifp_req_if.sink   req_chan,
   wifp_rsp_if.source rsp_chan
);
   import wifp_pkg::*;

   frame_sum_type sum;
   frame_sum_type s1_ff, s1_in;
   logic          s1_valid_ff, s1_valid_in;

   logic [INT_PROD_W-1:0]  s2_int_prod_ff, s2_int_prod_in;
   logic [FRAC_PROD_W-1:0] s2_frac_prod_ff, s2_frac_prod_in;
   logic                   s2_neg_ff, s2_ok_ff, s2_dev_ok_ff;
   logic [DEV_W-1:0]       s2_dev_ff;
   logic                   s2_valid_ff, s2_valid_in;

   logic                   out_valid_ff, out_valid_in;
   logic [DEV_W-1:0]       out_dev_ff;
   logic                   out_acc_ff;
   logic [WEIGHT_W-1:0]    out_weight_ff, out_weight_in;
   logic                   out_wvalid_ff, out_wvalid_in;

   logic [WEIGHT_W-1:0]    weight_store_ff [DEVICE_COUNT];
   logic [DEVICE_COUNT-1:0] valid_store_ff;

   logic                   req_fire, out_load, s2_load, s1_free;
   logic [WEIGHT_W-1:0]    mag, weight_new;
   logic [DEV_IDX_W-1:0]   s2_idx;

   assign out_load = s2_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign s2_load  = s1_valid_ff && (!s2_valid_ff || out_load);
   assign s1_free  = !s1_valid_ff || s2_load;

   assign req_chan.ready = s1_free;
   assign req_fire       = req_chan.valid && s1_free;

   wifp_byte_check u_check (
      .clock     (clock),
      .reset     (reset),
      .step      (req_fire),
      .data_byte (req_chan.data_byte),
      .frame_end (req_chan.frame_end),
      .device    (req_chan.device),
      .frame_sum (sum)
   );

   // Stage 1: frame summary captured on the last byte.
   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (s2_load) s1_valid_in = 1'b0;
      if (req_fire && req_chan.frame_end) begin
         s1_in       = sum;
         s1_valid_in = 1'b1;
      end
   end

   // Stage 2: scale the integer and fraction parts.
   assign s2_int_prod_in  = INT_PROD_W'(s1_ff.int_acc) * INT_PROD_W'(INT_SCALE);
   assign s2_frac_prod_in = FRAC_PROD_W'(s1_ff.frac_acc)
                          * FRAC_PROD_W'(frac_scale(s1_ff.frac_digits));

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (out_load) s2_valid_in = 1'b0;
      if (s2_load) s2_valid_in = 1'b1;
   end

   // Stage 3: sum, sign and store update. Negating zero leaves zero.
   assign mag        = WEIGHT_W'(s2_int_prod_ff) + WEIGHT_W'(s2_frac_prod_ff);
   assign weight_new = s2_neg_ff ? (~mag + 1'b1) : mag;
   assign s2_idx     = s2_dev_ff[DEV_IDX_W-1:0];

   always_comb begin
      out_weight_in = '0;
      out_wvalid_in = 1'b0;
      if (s2_ok_ff) begin
         out_weight_in = weight_new;
         out_wvalid_in = 1'b1;
      end else if (s2_dev_ok_ff && valid_store_ff[s2_idx]) begin
         out_weight_in = weight_store_ff[s2_idx];
         out_wvalid_in = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) out_valid_in = 1'b0;
      if (out_load) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         valid_store_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load && s2_ok_ff) valid_store_ff[s2_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s2_load) begin
         s2_int_prod_ff  <= s2_int_prod_in;
         s2_frac_prod_ff <= s2_frac_prod_in;
         s2_neg_ff       <= s1_ff.sign_negative;
         s2_ok_ff        <= s1_ff.ok;
         s2_dev_ok_ff    <= s1_ff.dev_ok;
         s2_dev_ff       <= s1_ff.device;
      end
      if (out_load) begin
         out_dev_ff    <= s2_dev_ff;
         out_acc_ff    <= s2_ok_ff;
         out_weight_ff <= out_weight_in;
         out_wvalid_ff <= out_wvalid_in;
         if (s2_ok_ff) weight_store_ff[s2_idx] <= weight_new;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.device_out   = out_dev_ff;
   assign rsp_chan.accepted     = out_acc_ff;
   assign rsp_chan.weight_micro = out_weight_ff;
   assign rsp_chan.weight_valid = out_wvalid_ff;

   // An accepted frame always leaves its device marked valid.
   a_accept_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.accepted |-> rsp_chan.weight_valid)
      else $error("accepted frame without valid weight");

   // Out-of-range devices are never accepted.
   a_accept_device_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.accepted |->
         ({1'b0, rsp_chan.device_out} < 4'(DEVICE_COUNT)))
      else $error("accepted frame for out-of-range device");

   // A device without a stored weight reports zero.
   a_empty_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.weight_valid |-> rsp_chan.weight_micro == '0)
      else $error("nonzero weight for device without a stored frame");

   // The end-of-frame stages only fill from a transfer that carries frame_end.
   a_stage_fill: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff ##1 s1_valid_ff |->
         $past(req_chan.valid && req_chan.ready && req_chan.frame_end))
      else $error("end-of-frame stage filled without a frame end");

endmodule

`default_nettype wire

// ===== src/wifp_byte_check.sv =====
`default_nettype none

module wifp_byte_check (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           step,
   input  wire [wifp_pkg::BYTE_W-1:0]    data_byte,
   input  wire                           frame_end,
   input  wire [wifp_pkg::DEV_W-1:0]     device,
   output wifp_pkg::frame_sum_type       frame_sum
);
   import wifp_pkg::*;

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  bad_ff, bad_in, bad_upd;
   logic                  hdr_ff, hdr_in, hdr_upd;
   logic                  neg_ff, neg_in, neg_upd;
   logic                  dot_ff, dot_in, dot_upd;
   logic [INT_ACC_W-1:0]  int_ff, int_in, int_upd;
   logic [FRAC_ACC_W-1:0] frac_ff, frac_in, frac_upd;
   logic [FRAC_CNT_W-1:0] fcnt_ff, fcnt_in, fcnt_upd;
   logic [BYTE_W-1:0]     digit;
   logic                  long_enough;
   logic                  dev_ok;

   assign digit = data_byte - CHAR_0;

   always_comb begin
      bad_upd  = bad_ff;
      hdr_upd  = hdr_ff;
      neg_upd  = neg_ff;
      dot_upd  = dot_ff;
      int_upd  = int_ff;
      frac_upd = frac_ff;
      fcnt_upd = fcnt_ff;
      case (pos_ff) inside
         POS_HDR_0: hdr_upd = (data_byte == CHAR_S);
         POS_HDR_1: hdr_upd = hdr_ff && (data_byte == CHAR_T);
         POS_COMMA_A, POS_COMMA_B: begin
            if (hdr_ff && data_byte != CHAR_COMMA) bad_upd = 1'b1;
         end
         POS_SIGN: begin
            if (data_byte == CHAR_PLUS) neg_upd = 1'b0;
            else if (data_byte == CHAR_MINUS) neg_upd = 1'b1;
            else bad_upd = 1'b1;
         end
         [POS_NUM_LO:POS_NUM_HI]: begin
            if (data_byte == CHAR_DOT) begin
               if (dot_ff) bad_upd = 1'b1;
               dot_upd = 1'b1;
            end else if (data_byte inside {[CHAR_0:CHAR_9]}) begin
               // Times ten as two shifts and an add.
               if (!dot_ff) begin
                  int_upd = (int_ff << 3) + (int_ff << 1) + INT_ACC_W'(digit);
               end else begin
                  frac_upd = (frac_ff << 3) + (frac_ff << 1) + FRAC_ACC_W'(digit);
                  fcnt_upd = fcnt_ff + 1'b1;
               end
            end else begin
               bad_upd = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign long_enough = ({1'b0, pos_ff} + 6'd1) >= 6'(MIN_FRAME_BYTES);
   assign dev_ok      = ({1'b0, device}) < 4'(DEVICE_COUNT);

   always_comb begin
      frame_sum.int_acc       = int_upd;
      frame_sum.frac_acc      = frac_upd;
      frame_sum.frac_digits   = fcnt_upd;
      frame_sum.sign_negative = neg_upd;
      frame_sum.ok            = !bad_upd && long_enough && dev_ok;
      frame_sum.dev_ok        = dev_ok;
      frame_sum.device        = device;
   end

   always_comb begin
      pos_in  = pos_ff;
      bad_in  = bad_ff;
      hdr_in  = hdr_ff;
      neg_in  = neg_ff;
      dot_in  = dot_ff;
      int_in  = int_ff;
      frac_in = frac_ff;
      fcnt_in = fcnt_ff;
      if (step) begin
         if (frame_end) begin
            pos_in  = '0;
            bad_in  = 1'b0;
            hdr_in  = 1'b0;
            neg_in  = 1'b0;
            dot_in  = 1'b0;
            int_in  = '0;
            frac_in = '0;
            fcnt_in = '0;
         end else begin
            pos_in  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
            bad_in  = bad_upd;
            hdr_in  = hdr_upd;
            neg_in  = neg_upd;
            dot_in  = dot_upd;
            int_in  = int_upd;
            frac_in = frac_upd;
            fcnt_in = fcnt_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         bad_ff  <= 1'b0;
         hdr_ff  <= 1'b0;
         neg_ff  <= 1'b0;
         dot_ff  <= 1'b0;
         int_ff  <= '0;
         frac_ff <= '0;
         fcnt_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         bad_ff  <= bad_in;
         hdr_ff  <= hdr_in;
         neg_ff  <= neg_in;
         dot_ff  <= dot_in;
         int_ff  <= int_in;
         frac_ff <= frac_in;
         fcnt_ff <= fcnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== test/weigh_indicator_frame_parser_top_test.sv =====
module weigh_indicator_frame_parser_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wifp_pkg::*;

   typedef struct {
      logic [DEV_W-1:0]           device_out;
      logic                       accepted;
      logic signed [WEIGHT_W-1:0] weight_micro;
      logic                       weight_valid;
   } weighing_type;

   logic clock;
   logic reset;

   wifp_req_if req_chan ();
   wifp_rsp_if rsp_chan ();

   weigh_indicator_frame_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Parser state as the block should hold it.
   logic [POS_W-1:0]      byte_pos;
   logic                  frame_bad;
   logic                  header_st;
   logic                  negative;
   logic                  dot_seen;
   logic [INT_ACC_W-1:0]  int_digits;
   logic [FRAC_ACC_W-1:0] frac_digits;
   logic [FRAC_CNT_W-1:0] frac_count;
   logic [WEIGHT_W-1:0]   stored_weight [DEVICE_COUNT];
   logic                  stored_valid  [DEVICE_COUNT];

   weighing_type expected_weighings[$];

   bit failed;
   bit sender_idles;
   bit sink_stalls;
   int bytes_sent;
   int frames_ended;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("weigh_indicator_frame_parser_top verification failed");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic void clear_frame_state();
      byte_pos    = '0;
      frame_bad   = 1'b0;
      header_st   = 1'b0;
      negative    = 1'b0;
      dot_seen    = 1'b0;
      int_digits  = '0;
      frac_digits = '0;
      frac_count  = '0;
   endfunction

   function automatic void parse_indicator_byte(input logic [BYTE_W-1:0] b, input logic last,
                                                input logic [DEV_W-1:0] dev);
      int unsigned length;
      int unsigned scale;
      logic [63:0] magnitude;
      logic        ok;
      weighing_type w;
      if (byte_pos == POS_HDR_0) begin
         header_st = (b == CHAR_S);
      end else if (byte_pos == POS_HDR_1) begin
         header_st = header_st && (b == CHAR_T);
      end else if (byte_pos == POS_COMMA_A || byte_pos == POS_COMMA_B) begin
         if (header_st && b != CHAR_COMMA) frame_bad = 1'b1;
      end else if (byte_pos == POS_SIGN) begin
         if (b == CHAR_PLUS) negative = 1'b0;
         else if (b == CHAR_MINUS) negative = 1'b1;
         else frame_bad = 1'b1;
      end else if (byte_pos >= POS_NUM_LO && byte_pos <= POS_NUM_HI) begin
         if (b == CHAR_DOT) begin
            if (dot_seen) frame_bad = 1'b1;
            dot_seen = 1'b1;
         end else if (b >= CHAR_0 && b <= CHAR_9) begin
            if (!dot_seen) begin
               int_digits = INT_ACC_W'(int_digits * 10 + (b - CHAR_0));
            end else begin
               frac_digits = FRAC_ACC_W'(frac_digits * 10 + (b - CHAR_0));
               frac_count  = frac_count + 1'b1;
            end
         end else begin
            frame_bad = 1'b1;
         end
      end
      length = byte_pos + 1;
      if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
      if (!last) return;

      ok = !frame_bad && length >= MIN_FRAME_BYTES && dev < DEVICE_COUNT;
      if (ok) begin
         // Fraction digits are scaled up to six decimal places.
         scale = 1000000;
         for (int i = 0; i < frac_count && i < 6; i++) scale = scale / 10;
         magnitude = 64'(int_digits) * 64'd1000000 + 64'(frac_digits) * 64'(scale);
         if (negative) magnitude = -magnitude;
         stored_weight[dev] = magnitude[WEIGHT_W-1:0];
         stored_valid[dev]  = 1'b1;
      end
      w.device_out   = dev;
      w.accepted     = ok;
      w.weight_micro = '0;
      w.weight_valid = 1'b0;
      if (dev < DEVICE_COUNT) begin
         w.weight_micro = stored_weight[dev];
         w.weight_valid = stored_valid[dev];
      end
      expected_weighings.push_back(w);
      frames_ended++;
      clear_frame_state();
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                            input logic [DEV_W-1:0] dev);
      int gap;
      gap = sender_idles ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.frame_end <= last;
      req_chan.device    <= dev;
      do @(posedge clock); while (!req_chan.ready);
      parse_indicator_byte(b, last, dev);
      bytes_sent++;
   endtask

   // The device only matters on the last byte; the others carry noise there.
   task automatic send_frame(input logic [BYTE_W-1:0] frame[$], input logic [DEV_W-1:0] dev);
      for (int i = 0; i < frame.size(); i++) begin
         if (i == frame.size() - 1) send_byte(frame[i], 1'b1, dev);
         else send_byte(frame[i], 1'b0, DEV_W'($urandom_range(0, 7)));
      end
   endtask

   task automatic send_ascii(input string s, input logic [DEV_W-1:0] dev);
      logic [BYTE_W-1:0] frame[$];
      for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
      send_frame(frame, dev);
   endtask

   task automatic wait_for_weighings();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_weighings.size() != 0) @(posedge clock);
   endtask

   function automatic void compose_frame(output logic [BYTE_W-1:0] frame[$]);
      int total;
      int dot_at;
      int r;
      bit zeros;
      frame = {};
      if ($urandom_range(0, 99) < 5) begin
         total = $urandom_range(1, 24);
         repeat (total) frame.push_back(BYTE_W'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 4) != 0) begin
         frame.push_back(CHAR_S);
         frame.push_back(CHAR_T);
      end else begin
         frame.push_back(BYTE_W'($urandom_range(0, 255)));
         frame.push_back(BYTE_W'($urandom_range(0, 255)));
      end
      frame.push_back(CHAR_COMMA);
      frame.push_back(BYTE_W'($urandom_range(0, 255)));
      frame.push_back(BYTE_W'($urandom_range(0, 255)));
      frame.push_back(CHAR_COMMA);
      frame.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
      dot_at = $urandom_range(0, 1) ? $urandom_range(0, 6) : -1;
      zeros  = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < 7; i++) begin
         if (i == dot_at) frame.push_back(CHAR_DOT);
         else if (zeros) frame.push_back(CHAR_0);
         else frame.push_back(BYTE_W'(CHAR_0 + $urandom_range(0, 9)));
      end
      r = $urandom_range(0, 99);
      if (r < 10) total = $urandom_range(14, 15);
      else if (r < 95) total = $urandom_range(16, 20);
      else total = $urandom_range(21, 40);
      while (frame.size() < total) frame.push_back(BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 20)
         frame[$urandom_range(0, frame.size() - 1)] = BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic test_basic_weights();
      send_ascii("ST,GS,+1234567kg", 3'd0);
      send_ascii("ST,GS,-9999999kg", 3'd1);
      send_ascii("ST,NT,+0000000kg", 3'd2);
      // Minus zero must be stored as plain zero.
      send_ascii("ST,GS,-000.000kg", 3'd3);
      send_ascii("ST,GS,+0000001kg", 3'd0);
   endtask

   task automatic test_fraction_forms();
      send_ascii("ST,GS,+.123456kg", 3'd0);
      send_ascii("ST,GS,-123456.kg", 3'd1);
      send_ascii("ST,GS,+12.3456kg", 3'd2);
      send_ascii("US,GS,-.000001kg", 3'd3);
   endtask

   task automatic test_malformed_frames();
      logic [BYTE_W-1:0] frame[$];
      send_ascii("ST;GS,+1234567kg", 3'd0);
      send_ascii("ST,GS;+1234567kg", 3'd1);
      send_ascii("ST,GS,*1234567kg", 3'd2);
      send_ascii("ST,GS,+1.2.345kg", 3'd3);
      send_ascii("ST,GS,+12a4567kg", 3'd0);
      // Without the ST header the comma positions are not checked.
      send_ascii("SX;GS;+7654321kg", 3'd1);
      frame = {CHAR_S, CHAR_T, CHAR_COMMA, 8'hFF, 8'h00, CHAR_COMMA, CHAR_PLUS,
               CHAR_0, 8'hFF, CHAR_0, 8'h00, CHAR_0, CHAR_0, CHAR_0, 8'h00, 8'hFF};
      send_frame(frame, 3'd2);
   endtask

   task automatic test_length_limits();
      send_ascii("ST,GS,+1234567k", 3'd0);
      send_ascii("S", 3'd1);
      send_ascii("ST,GS,-0012345kg", 3'd1);
      // Bytes past the number field are never checked, even beyond saturation.
      send_ascii("ST,GS,+0000042kg;;;;;;;;;;;;;;;;;;;;;;;;", 3'd2);
   endtask

   task automatic test_device_range();
      for (int d = DEVICE_COUNT; d < 8; d++) send_ascii("ST,GS,+1111111kg", DEV_W'(d));
      send_ascii("ST,GS,+2222222kg", 3'd3);
   endtask

   // Back-to-back frames into a stalling sink after a full drain.
   task automatic test_drain_pause();
      send_ascii("ST,GS,+3333333kg", 3'd0);
      wait_for_weighings();
      sender_idles = 1'b0;
      sink_stalls  = 1'b1;
      repeat (4) send_ascii("ST,GS,-4.44444kg", 3'd1);
      sender_idles = 1'b1;
   endtask

   task automatic test_random_frames();
      logic [BYTE_W-1:0] frame[$];
      logic [DEV_W-1:0]  dev;
      int                start_frames;
      start_frames = frames_ended;
      while (bytes_sent < 750) begin
         if ($urandom_range(0, 9) == 0) sender_idles = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 9) == 0) sink_stalls  = ($urandom_range(0, 2) != 0);
         compose_frame(frame);
         if ($urandom_range(0, 99) < 85) dev = DEV_W'($urandom_range(0, DEVICE_COUNT - 1));
         else dev = DEV_W'($urandom_range(DEVICE_COUNT, 7));
         send_frame(frame, dev);
         if (frames_ended - start_frames == 8) wait_for_weighings();
      end
   endtask

   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_stalls && stall_left == 0 && $urandom_range(0, 99) < 30)
            stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_weighings
      weighing_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_weighings.size() == 0) begin
            $error("response transfer with no frame end waiting for it");
            failed = 1'b1;
         end else begin
            want = expected_weighings.pop_front();
            if (rsp_chan.device_out !== want.device_out) begin
               $error("device_out: expected %0d, got %0d", want.device_out, rsp_chan.device_out);
               failed = 1'b1;
            end
            if (rsp_chan.accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_chan.accepted);
               failed = 1'b1;
            end
            if (rsp_chan.weight_micro !== want.weight_micro) begin
               $error("weight_micro: expected %0d, got %0d", want.weight_micro,
                      rsp_chan.weight_micro);
               failed = 1'b1;
            end
            if (rsp_chan.weight_valid !== want.weight_valid) begin
               $error("weight_valid: expected %0d, got %0d", want.weight_valid,
                      rsp_chan.weight_valid);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin : main
      int waited;
      failed       = 1'b0;
      sender_idles = 1'b1;
      sink_stalls  = 1'b1;
      bytes_sent   = 0;
      frames_ended = 0;
      clear_frame_state();
      for (int d = 0; d < DEVICE_COUNT; d++) begin
         stored_weight[d] = '0;
         stored_valid[d]  = 1'b0;
      end
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.frame_end <= 1'b0;
      req_chan.device    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_basic_weights();
      test_fraction_forms();
      test_malformed_frames();
      test_length_limits();
      test_device_range();
      test_drain_pause();
      test_random_frames();

      req_chan.valid <= 1'b0;
      waited = 0;
      while (expected_weighings.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (expected_weighings.size() != 0) begin
         $error("%0d frame ends never got a response", expected_weighings.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("weigh_indicator_frame_parser_top verification clean");
      end else begin
         $display("weigh_indicator_frame_parser_top verification failed");
      end
      $finish;
   end

endmodule
